### rtl/core/multichannel_current_monitor_defines.svh
// Assertion macros for the current monitor port checks.
`ifndef MULTICHANNEL_CURRENT_MONITOR_DEFINES_SVH
`define MULTICHANNEL_CURRENT_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("current monitor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("current monitor check failed");

`endif

### rtl/core/mcm_pkg.sv
// Shared constants, register codes and types of the current monitor.
package mcm_pkg;

    localparam int WINDOW_DEPTH  = 16;
    localparam int CHANNEL_COUNT = 4;

    localparam int SAMPLE_W   = 10;
    localparam int KEPT_W     = 8;
    localparam int TOTAL_W    = 14;
    localparam int CH_W       = $clog2(CHANNEL_COUNT);
    localparam int WIN_W      = 3;
    localparam int SHIFT_W    = 3;
    localparam int LIMIT_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [WIN_W-1:0]   MEASURE_WINDOW_RST = 3'd4;
    localparam logic [SHIFT_W-1:0] MEAN_SHIFT_RST     = 3'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST     = 14'd200;
    localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST      = 14'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEASURE_WINDOW = 2'd0,
        CFG_MEAN_SHIFT     = 2'd1,
        CFG_LIMIT_HIGH     = 2'd2,
        CFG_LIMIT_LOW      = 2'd3
    } t_cfg_reg;

    // Status of one channel toward the top level.
    typedef struct packed {
        logic [TOTAL_W-1:0] mean;      // stored mean
        logic [TOTAL_W-1:0] new_mean;  // mean if the kept sample enters now
    } t_chan_stat;

endpackage

### rtl/core/mcm_tap_cell.sv
// One 8-bit tap of a channel's sample window; shifts toward the tail.
module mcm_tap_cell
    import mcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [KEPT_W-1:0] i_data,
    output logic [KEPT_W-1:0] o_data
);

    logic [KEPT_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

### rtl/core/mcm_channel.sv
// One channel: chain of window taps, running total and mean.
module mcm_channel
    import mcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic [KEPT_W-1:0]  i_kept,
    input  logic [SHIFT_W-1:0] i_mean_shift,
    output t_chan_stat         o_stat
);

    logic [KEPT_W-1:0]  w_tap [WINDOW_DEPTH+1];
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W-1:0] r_mean;
    logic [TOTAL_W-1:0] n_mean;

    assign w_tap[0] = i_kept;

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_tap
        mcm_tap_cell u_tap (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_data  (w_tap[k]),
            .o_data  (w_tap[k+1])
        );
    end

    // Oldest entry falls off the tail as the new one enters the head.
    always_comb begin
        n_total = r_total - TOTAL_W'(w_tap[WINDOW_DEPTH]) + TOTAL_W'(i_kept);
        n_mean  = n_total >> i_mean_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_mean  <= '0;
        end else if (i_shift) begin
            r_total <= n_total;
            r_mean  <= n_mean;
        end
    end

    assign o_stat.mean     = r_mean;
    assign o_stat.new_mean = n_mean;

endmodule

### rtl/core/multichannel_current_monitor.sv
// Four-channel current monitor: decimated moving average with hysteresis limits.
// Each accepted sample item's result item is registered and shows in the next cycle.
// Throughput: one item per cycle when not stalled; the window update is a single
// total add/sub in the selected channel; the limit check reads the next channel.
// Reset (synchronous, active low) clears all windows, totals, means and counters
// at once, sets every drive enable and loads the register defaults; no sweep.
module multichannel_current_monitor
    import mcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_window_done,
    output logic [CH_W-1:0]       o_updated_channel,
    output logic [TOTAL_W-1:0]    o_updated_mean,
    output logic [CH_W-1:0]       o_next_channel,
    output logic [CHANNEL_COUNT-1:0] o_enable_mask,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [WIN_W-1:0]   r_measure_window;
    logic [SHIFT_W-1:0] r_mean_shift;
    logic [LIMIT_W-1:0] r_limit_high;
    logic [LIMIT_W-1:0] r_limit_low;

    // Sequencing state
    logic [WIN_W-1:0]         r_dec_cnt;
    logic [WIN_W-1:0]         n_dec_cnt;
    logic [CH_W-1:0]          r_ch;
    logic [CH_W-1:0]          n_ch;
    logic [CHANNEL_COUNT-1:0] r_drive;
    logic [CHANNEL_COUNT-1:0] n_drive;

    // Result register
    logic               r_out_valid;
    logic               r_window_done;
    logic [CH_W-1:0]    r_upd_ch;
    logic [TOTAL_W-1:0] r_upd_mean;

    logic               w_accept;
    logic               w_keep;
    logic [KEPT_W-1:0]  w_kept;
    logic [TOTAL_W-1:0] w_check_mean;
    t_chan_stat         w_stat [CHANNEL_COUNT];

    // Register writes are always taken; the user must write only while the block is idle, unenforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measure_window <= MEASURE_WINDOW_RST;
            r_mean_shift     <= MEAN_SHIFT_RST;
            r_limit_high     <= LIMIT_HIGH_RST;
            r_limit_low      <= LIMIT_LOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MEASURE_WINDOW: r_measure_window <= i_cfg_data[WIN_W-1:0];
                CFG_MEAN_SHIFT:     r_mean_shift     <= i_cfg_data[SHIFT_W-1:0];
                CFG_LIMIT_HIGH:     r_limit_high     <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_LOW:      r_limit_low      <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Take a new item unless the result register is full and held.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decimation: bump the count (wrapping), keep when it reaches the window.
    always_comb begin
        n_dec_cnt = WIN_W'(r_dec_cnt + 1'b1);
        w_keep    = (n_dec_cnt >= r_measure_window);
        if (w_keep) begin
            n_dec_cnt = '0;
        end
    end

    // Drop the two low bits of the converter result.
    assign w_kept = i_sample[SAMPLE_W-1 -: KEPT_W];

    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
        mcm_channel u_chan (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_accept && w_keep && (r_ch == CH_W'(c))),
            .i_kept       (w_kept),
            .i_mean_shift (r_mean_shift),
            .o_stat       (w_stat[c])
        );
    end

    // Round-robin advance on a keep. The channel checked afterwards is never
    // the one just updated, so its stored mean is the current one.
    always_comb begin
        n_ch         = w_keep ? CH_W'(r_ch + 1'b1) : r_ch;
        w_check_mean = w_stat[n_ch].mean;
        n_drive      = r_drive;
        priority if (w_check_mean > r_limit_high) begin
            n_drive[n_ch] = 1'b0;
        end else if (w_check_mean < r_limit_low) begin
            n_drive[n_ch] = 1'b1;
        end else begin
            n_drive = r_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_cnt <= '0;
            r_ch      <= '0;
            r_drive   <= '1;
        end else if (w_accept) begin
            r_dec_cnt <= n_dec_cnt;
            r_ch      <= n_ch;
            r_drive   <= n_drive;
        end
    end

    // Result register: load on accept, empty once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_window_done <= w_keep;
            r_upd_ch      <= w_keep ? r_ch : '0;
            r_upd_mean    <= w_keep ? w_stat[r_ch].new_mean : '0;
        end
    end

    // Channel and mask state change only on accept, together with the result
    // register, so they serve directly as the result's last two fields.
    assign o_out_valid       = r_out_valid;
    assign o_window_done     = r_window_done;
    assign o_updated_channel = r_upd_ch;
    assign o_updated_mean    = r_upd_mean;
    assign o_next_channel    = r_ch;
    assign o_enable_mask     = r_drive;

endmodule

### rtl/core/mcm_checker.sv
// Port-level checks of the current monitor, bound to the top level.
`include "multichannel_current_monitor_defines.svh"

module mcm_port_checks
    import mcm_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_window_done,
    input logic [CH_W-1:0]          o_updated_channel,
    input logic [TOTAL_W-1:0]       o_updated_mean,
    input logic [CH_W-1:0]          o_next_channel,
    input logic [CHANNEL_COUNT-1:0] o_enable_mask
);

    // A held result keeps its mean and enable mask.
    `MCM_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_updated_mean) && $stable(o_enable_mask))

    // An accepted item always shows up as a result in the next cycle.
    `MCM_ASSERT_NEXT(a_item_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid)

    // A result without a window update carries zero channel and mean.
    `MCM_ASSERT_IMPL(a_idle_fields, i_clk, i_rst_n, o_out_valid && !o_window_done,
        (o_updated_channel == '0) && (o_updated_mean == '0))

    // After an update the multiplexer moves on to the following channel.
    `MCM_ASSERT_IMPL(a_round_robin, i_clk, i_rst_n, o_out_valid && o_window_done,
        o_next_channel == CH_W'(o_updated_channel + 1'b1))

endmodule

bind multichannel_current_monitor mcm_port_checks u_mcm_port_checks (.*);

### tb/sv/mcm_checker.sv
`timescale 1ns / 1ps
// Result checker for the current monitor: mirrors the block and compares every result item.
module mcm_checker
    import mcm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [SAMPLE_W-1:0]      i_sample,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_window_done,
    input  logic [CH_W-1:0]          i_updated_channel,
    input  logic [TOTAL_W-1:0]       i_updated_mean,
    input  logic [CH_W-1:0]          i_next_channel,
    input  logic [CHANNEL_COUNT-1:0] i_enable_mask,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output int                       o_error_count,
    output int                       o_pending
);

    localparam int RING_SIZE = CHANNEL_COUNT * WINDOW_DEPTH;
    localparam int PTR_W     = $clog2(WINDOW_DEPTH);

    typedef struct packed {
        logic                     window_done;
        logic [CH_W-1:0]          updated_channel;
        logic [TOTAL_W-1:0]       updated_mean;
        logic [CH_W-1:0]          next_channel;
        logic [CHANNEL_COUNT-1:0] enable_mask;
    } t_monitor_result;

    logic [WIN_W-1:0]         cfg_window;
    logic [SHIFT_W-1:0]       cfg_shift;
    logic [LIMIT_W-1:0]       cfg_limit_high;
    logic [LIMIT_W-1:0]       cfg_limit_low;

    logic [WIN_W-1:0]         decim_count;
    logic [CH_W-1:0]          sel_channel;
    logic [KEPT_W-1:0]        ring [RING_SIZE];
    logic [PTR_W-1:0]         ring_ptr [CHANNEL_COUNT];
    logic [TOTAL_W-1:0]       window_sum [CHANNEL_COUNT];
    logic [TOTAL_W-1:0]       chan_mean [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] drive_mask;

    t_monitor_result          monitor_results_q [$];
    int                       error_count;
    int                       result_index;

    task automatic report_error(input string msg);
        $display("[%0t] result %0d: %s", $time, result_index, msg);
        error_count++;
    endtask

    // One sample item: decimate, update the ring and mean, then run the limit check.
    task automatic monitor_step(input logic [SAMPLE_W-1:0] sample, output t_monitor_result res);
        logic [KEPT_W-1:0] kept;
        logic [CH_W-1:0]   ch;
        int                slot;
        res = '0;
        decim_count = decim_count + 1'b1;
        if (decim_count >= cfg_window) begin
            decim_count = '0;
            kept = sample[SAMPLE_W-1:SAMPLE_W-KEPT_W];
            ch = sel_channel;
            slot = ch * WINDOW_DEPTH + ring_ptr[ch];
            window_sum[ch] = window_sum[ch] - ring[slot] + kept;
            ring[slot] = kept;
            ring_ptr[ch] = (ring_ptr[ch] == WINDOW_DEPTH - 1) ? '0 : ring_ptr[ch] + 1'b1;
            chan_mean[ch] = window_sum[ch] >> cfg_shift;
            res.window_done = 1'b1;
            res.updated_channel = ch;
            res.updated_mean = chan_mean[ch];
            sel_channel = ch + 1'b1;
        end
        // high limit wins when the limits overlap
        ch = sel_channel;
        if (chan_mean[ch] > cfg_limit_high) begin
            drive_mask[ch] = 1'b0;
        end else if (chan_mean[ch] < cfg_limit_low) begin
            drive_mask[ch] = 1'b1;
        end
        res.next_channel = sel_channel;
        res.enable_mask = drive_mask;
    endtask

    always @(posedge i_clk) begin : watch
        t_monitor_result got;
        t_monitor_result want;
        if (!i_rst_n) begin
            cfg_window = MEASURE_WINDOW_RST;
            cfg_shift = MEAN_SHIFT_RST;
            cfg_limit_high = LIMIT_HIGH_RST;
            cfg_limit_low = LIMIT_LOW_RST;
            decim_count = '0;
            sel_channel = '0;
            for (int k = 0; k < RING_SIZE; k++) ring[k] = '0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                ring_ptr[c] = '0;
                window_sum[c] = '0;
                chan_mean[c] = '0;
            end
            drive_mask = '1;
            monitor_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MEASURE_WINDOW: cfg_window = i_cfg_data[WIN_W-1:0];
                    CFG_MEAN_SHIFT:     cfg_shift = i_cfg_data[SHIFT_W-1:0];
                    CFG_LIMIT_HIGH:     cfg_limit_high = i_cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT_LOW:      cfg_limit_low = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier item, so compare before predicting
            if (i_out_valid && !i_out_stall) begin
                got = {i_window_done, i_updated_channel, i_updated_mean,
                       i_next_channel, i_enable_mask};
                if (monitor_results_q.size() == 0) begin
                    report_error("result item with no item pending");
                end else begin
                    want = monitor_results_q.pop_front();
                    if (got.window_done !== want.window_done)
                        report_error($sformatf("window_done got %0b expected %0b",
                                               got.window_done, want.window_done));
                    if (got.updated_channel !== want.updated_channel)
                        report_error($sformatf("updated_channel got %0d expected %0d",
                                               got.updated_channel, want.updated_channel));
                    if (got.updated_mean !== want.updated_mean)
                        report_error($sformatf("updated_mean got %0d expected %0d",
                                               got.updated_mean, want.updated_mean));
                    if (got.next_channel !== want.next_channel)
                        report_error($sformatf("next_channel got %0d expected %0d",
                                               got.next_channel, want.next_channel));
                    if (got.enable_mask !== want.enable_mask)
                        report_error($sformatf("enable_mask got %b expected %b",
                                               got.enable_mask, want.enable_mask));
                end
                result_index++;
            end
            if (i_in_valid && !i_in_stall) begin
                monitor_step(i_sample, want);
                monitor_results_q.push_back(want);
            end
        end
        o_pending <= monitor_results_q.size();
        o_error_count <= error_count;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the current monitor testbench: clock, reset, stimulus, stall patterns and verdict.
module tb_top;
    import mcm_pkg::*;

    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_KEPT_TOTAL  = WINDOW_DEPTH * (2 ** KEPT_W - 1);
    localparam int LIMIT_MAX       = 2 ** LIMIT_W - 1;
    localparam int SAMPLE_MAX      = 2 ** SAMPLE_W - 1;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [SAMPLE_W-1:0]      i_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_window_done;
    logic [CH_W-1:0]          o_updated_channel;
    logic [TOTAL_W-1:0]       o_updated_mean;
    logic [CH_W-1:0]          o_next_channel;
    logic [CHANNEL_COUNT-1:0] o_enable_mask;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int mismatch_count;
    int pending_count;

    // Idling knobs, set per phase by the stimulus process.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // Each increment asks the receiver for one long hold-off.
    int hold_requests = 0;

    int quiet_cycles = 0;

    multichannel_current_monitor u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample          (i_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_window_done     (o_window_done),
        .o_updated_channel (o_updated_channel),
        .o_updated_mean    (o_updated_mean),
        .o_next_channel    (o_next_channel),
        .o_enable_mask     (o_enable_mask),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    mcm_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_sample          (i_sample),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_window_done     (o_window_done),
        .i_updated_channel (o_updated_channel),
        .i_updated_mean    (o_updated_mean),
        .i_next_channel    (o_next_channel),
        .i_enable_mask     (o_enable_mask),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_error_count     (mismatch_count),
        .o_pending         (pending_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: stall at the phase's rate, or hold stall for a long stretch on request
    // so that the block backs up and stalls its sample input.
    always @(posedge i_clk) begin : receiver
        int hold_served;
        int hold_left;
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample item, after a random idle gap, and hold it until accepted.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted result item has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Leave i_cfg_valid high on return; the caller drops it after the last write.
    task automatic write_reg(input t_cfg_reg idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write all four registers; call only while the block is idle.
    task automatic load_settings(input int window, input int shift, input int high, input int low);
        write_reg(CFG_MEASURE_WINDOW, window);
        write_reg(CFG_MEAN_SHIFT, shift);
        write_reg(CFG_LIMIT_HIGH, high);
        write_reg(CFG_LIMIT_LOW, low);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SAMPLE_W-1:0] edge_samples [8];
        int window;
        int shift;
        int high;
        int low;
        int level;
        int burst_left;
        int value;

        edge_samples = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1023, 10'd3, 10'd1020, 10'd512};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then window of zero (keep every sample) with
        // no shift, then longest window with the largest shift and overlapping limits.
        foreach (edge_samples[k]) send_sample(edge_samples[k]);
        wait_for_results();
        load_settings(0, 0, 300, 100);
        for (int k = 0; k < 8; k++)
            send_sample(k < 6 ? SAMPLE_W'(SAMPLE_MAX) : edge_samples[k]);
        wait_for_results();
        load_settings(7, 7, 0, LIMIT_MAX);
        foreach (edge_samples[k]) send_sample(edge_samples[k]);
        for (int k = 0; k < 4; k++) send_sample(SAMPLE_W'(SAMPLE_MAX));
        wait_for_results();

        // Random phases: each one picks settings, an idling pattern and a stream of
        // bursts around a level, so that the means drift across the limits.
        burst_left = 0;
        level = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                window = 1;
                shift = 6;
            end else begin
                window = $urandom_range(0, 7);
                shift = $urandom_range(0, 7);
            end
            high = $urandom_range(0, MAX_KEPT_TOTAL >> shift);
            low = $urandom_range(0, high);
            if ($urandom_range(5) == 0) low = high + $urandom_range(1, 40);
            if ($urandom_range(9) == 0) high = LIMIT_MAX;
            load_settings(window, shift, high, low);

            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            // back the block up while items keep coming
            if (ph == HOLD_PHASE) hold_requests++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    level = $urandom_range(0, SAMPLE_MAX);
                    if ($urandom_range(3) == 0) level = $urandom_range(1) ? SAMPLE_MAX : 0;
                    burst_left = $urandom_range(8, 60);
                end
                burst_left--;
                if ($urandom_range(4) == 0) begin
                    value = $urandom_range(0, SAMPLE_MAX);
                end else begin
                    value = level + $urandom_range(0, 64) - 32;
                    if (value < 0) value = 0;
                    if (value > SAMPLE_MAX) value = SAMPLE_MAX;
                end
                send_sample(value[SAMPLE_W-1:0]);
                // occasionally pause until everything has drained
                if ($urandom_range(49) == 0) wait_for_results();
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
